[rtl/core/smgt_pkg.sv]
`timescale 1ns / 1ps

package smgt_pkg;

    // Store depth default; the top level hands its parameter down from here.
    localparam int SMGT_MAX_ENTRIES = 1024;

    localparam int CNT_W       = 11;
    localparam int VAL_W       = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;

    localparam logic [VAL_W-1:0] SIGN_BIAS = 32'h8000_0000;
    localparam logic [VAL_W-1:0] GAP_INIT  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } smgt_state_t;

    // Control of the shared gap unit.
    typedef struct packed {
        logic load;
        logic step;
    } smgt_gap_ctrl_t;

    typedef struct packed {
        logic             status;
        logic [CNT_W-1:0] count;
        logic             span_ready;
        logic [VAL_W-1:0] shortest_span;
        logic [VAL_W-1:0] longest_span;
    } smgt_result_t;

    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] distinct;
    } smgt_status_t;

    // Flip the sign bit so that signed order becomes unsigned order.
    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v);
        return v ^ SIGN_BIAS;
    endfunction

endpackage

[rtl/core/set_min_max_gap_tracker_top.sv]
`timescale 1ns / 1ps

// Set tracker: keeps a bounded set of signed 32-bit values and reports the
// closest pair gap and the full range after every item.
// Channels:
//   s_  : one value per item in s_tdata.
//   m_  : one result per input item; status and span_ready in m_tuser,
//         count and the two spans in m_tdata.
//   cfg : write of the capacity register, always ready; write it only idle.
// Timing: a rejected item (store full) skips the scan and gives its result
// directly; the next item can be taken once that result is loaded. A stored
// or duplicate item scans the store once through the shared gap unit, one
// entry a cycle over the single RAM read port, and a duplicate ends the
// scan at its match; the result is loaded after the scan and, for a stored
// item, the write. s_tready is high only while no item is in progress.
// Reset clears counts, spans, flags and the capacity (every item is then
// rejected until capacity is written); store contents need no clearing.
// When the receiver stalls the result is held in the output register and
// the block waits before taking the next item.
module set_min_max_gap_tracker_top #(
    parameter int MAX_ENTRIES = smgt_pkg::SMGT_MAX_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [31:0] value (signed)
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic signed [31:0] s_tdata,
    // m_tdata: [10:0] count, [42:11] shortest_span, [74:43] longest_span,
    //          [79:75] zero
    // m_tuser: [0] status, [1] span_ready
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,
    // capacity register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    import smgt_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);

    logic                   out_free;
    logic                   res_load;
    smgt_result_t           result;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [VAL_W-1:0]       ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [VAL_W-1:0]       ram_rdata;
    smgt_gap_ctrl_t         gap_ctrl;
    logic [VAL_W-1:0]       gap_load;
    logic                   gap_eq;
    logic [VAL_W-1:0]       gap_best;
    smgt_status_t           stat;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // Capacity writes land at once.
    assign cfg_ready = 1'b1;

    smgt_seq #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_free  (out_free),
        .res_load  (res_load),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .gap_ctrl  (gap_ctrl),
        .gap_load  (gap_load),
        .gap_eq    (gap_eq),
        .gap_best  (gap_best),
        .stat      (stat)
    );

    // Value store: one write, one registered read a cycle.
    smgt_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared compare and subtract: equality test and running least gap.
    smgt_gap_unit u_gap (
        .aclk     (aclk),
        .ctrl     (gap_ctrl),
        .load_gap (gap_load),
        .stored   (ram_rdata),
        .value    (ram_wdata),
        .eq       (gap_eq),
        .best     (gap_best)
    );

    // Output register: free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        priority if (res_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, result.longest_span, result.shortest_span, result.count};
            m_tuser_next  = {result.span_ready, result.status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold payload while stalled.
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // The store never holds more values than have been counted.
    a_distinct_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.distinct <= stat.total)
        else $error("distinct count above total count");

    // One item at a time: input closes right after an item is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready while an item is in progress");

    // Count stays within the store.
    a_total_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(stat.total) <= 32'(MAX_ENTRIES))
        else $error("total count above store depth");

    // A result is only loaded into a free output register.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote an undelivered item");
`endif

endmodule

[rtl/core/smgt_ram.sv]
`timescale 1ns / 1ps

module smgt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/smgt_gap_unit.sv]
`timescale 1ns / 1ps

module smgt_gap_unit (
    input  logic                    aclk,
    input  smgt_pkg::smgt_gap_ctrl_t ctrl,
    input  logic [31:0]             load_gap,
    input  logic [31:0]             stored,
    input  logic [31:0]             value,
    output logic                    eq,
    output logic [31:0]             best
);

    import smgt_pkg::*;

    logic [VAL_W-1:0] key_s;
    logic [VAL_W-1:0] key_v;
    logic [VAL_W:0]   diff_sv;
    logic [VAL_W-1:0] diff_vs;
    logic [VAL_W-1:0] gap;
    logic [VAL_W-1:0] best_reg;
    logic [VAL_W-1:0] best_next;

    assign key_s   = order_key(stored);
    assign key_v   = order_key(value);
    assign diff_sv = {1'b0, key_s} - {1'b0, key_v};
    assign diff_vs = key_v - key_s;
    // borrow set means stored lies below value
    assign gap     = diff_sv[VAL_W] ? diff_vs : diff_sv[VAL_W-1:0];
    assign eq      = (stored == value);

    always_comb begin
        best_next = best_reg;
        priority if (ctrl.load) begin
            best_next = load_gap;
        end else if (ctrl.step && !eq && (gap < best_reg)) begin
            best_next = gap;
        end else begin
            best_next = best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
    end

    assign best = best_reg;

endmodule

[rtl/core/smgt_seq.sv]
`timescale 1ns / 1ps

module smgt_seq #(
    parameter int MAX_ENTRIES = smgt_pkg::SMGT_MAX_ENTRIES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [31:0]                    in_value,
    input  logic                           cfg_valid,
    input  logic [10:0]                    cfg_data,
    input  logic                           out_free,
    output logic                           res_load,
    output smgt_pkg::smgt_result_t         result,
    output logic                           ram_we,
    output logic [$clog2(MAX_ENTRIES)-1:0] ram_waddr,
    output logic [31:0]                    ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(MAX_ENTRIES)-1:0] ram_raddr,
    output smgt_pkg::smgt_gap_ctrl_t       gap_ctrl,
    output logic [31:0]                    gap_load,
    input  logic                           gap_eq,
    input  logic [31:0]                    gap_best,
    output smgt_pkg::smgt_status_t         stat
);

    import smgt_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);

    smgt_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] distinct_reg, distinct_next;
    logic             dup_reg, dup_next;
    logic [VAL_W-1:0] least_reg, least_next;
    logic [VAL_W-1:0] min_reg, min_next;
    logic [VAL_W-1:0] max_reg, max_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic             rej_reg, rej_next;

    logic [CNT_W-1:0]        cap_eff;
    logic                    full;
    logic                    accept;
    logic                    issue;
    logic                    last_data;
    logic [CNT_W+ADDR_W-1:0] raddr_wide;
    logic [CNT_W+ADDR_W-1:0] waddr_wide;
    logic                    span_ok;

    assign cap_eff   = ({21'd0, cap_reg} > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : cap_reg;
    assign full      = (total_reg >= cap_eff);
    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign issue     = (idx_reg < distinct_reg);
    assign last_data = pend_reg && (idx_reg == distinct_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    priority if (full)                  state_next = ST_OUT;
                    else if (distinct_reg == '0)        state_next = ST_WRITE;
                    else                                state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (pend_reg && gap_eq) state_next = ST_OUT;
                else if (last_data)              state_next = ST_WRITE;
                else                             state_next = ST_SCAN;
            end
            ST_WRITE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready      = (state_reg == ST_IDLE);
        res_load      = (state_reg == ST_OUT) && out_free;
        ram_re        = (state_reg == ST_SCAN) && issue;
        ram_we        = (state_reg == ST_WRITE);
        gap_ctrl.load = accept;
        gap_ctrl.step = (state_reg == ST_SCAN) && pend_reg;
    end

    assign raddr_wide = {{ADDR_W{1'b0}}, idx_reg};
    assign waddr_wide = {{ADDR_W{1'b0}}, distinct_reg};
    assign ram_raddr  = raddr_wide[ADDR_W-1:0];
    assign ram_waddr  = waddr_wide[ADDR_W-1:0];
    assign ram_wdata  = value_reg;
    assign gap_load   = least_reg;

    // datapath
    always_comb begin
        cap_next      = cap_reg;
        total_next    = total_reg;
        distinct_next = distinct_reg;
        dup_next      = dup_reg;
        least_next    = least_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        value_next    = value_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        rej_next      = rej_reg;

        if (cfg_valid) begin
            cap_next = cfg_data;
        end

        if (accept) begin
            value_next = in_value;
            rej_next   = full;
            idx_next   = '0;
            pend_next  = 1'b0;
        end

        if (state_reg == ST_SCAN) begin
            pend_next = issue;
            if (issue) begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (pend_reg && gap_eq) begin
                dup_next   = 1'b1;
                total_next = total_reg + CNT_W'(1);
            end
        end

        if (state_reg == ST_WRITE) begin
            least_next    = gap_best;
            distinct_next = distinct_reg + CNT_W'(1);
            total_next    = total_reg + CNT_W'(1);
            if (distinct_reg == '0) begin
                min_next = value_reg;
                max_next = value_reg;
            end else begin
                if (order_key(value_reg) < order_key(min_reg)) min_next = value_reg;
                if (order_key(value_reg) > order_key(max_reg)) max_next = value_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= '0;
            total_reg    <= '0;
            distinct_reg <= '0;
            dup_reg      <= 1'b0;
            least_reg    <= GAP_INIT;
            min_reg      <= '0;
            max_reg      <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            total_reg    <= total_next;
            distinct_reg <= distinct_next;
            dup_reg      <= dup_next;
            least_reg    <= least_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        idx_reg   <= idx_next;
        rej_reg   <= rej_next;
    end

    // result as seen once the item has updated the state
    assign span_ok              = (total_reg >= CNT_W'(2));
    assign result.status        = rej_reg;
    assign result.count         = total_reg;
    assign result.span_ready    = span_ok;
    assign result.shortest_span = (span_ok && !dup_reg) ? least_reg : '0;
    assign result.longest_span  = span_ok ? (order_key(max_reg) - order_key(min_reg)) : '0;

    assign stat.total    = total_reg;
    assign stat.distinct = distinct_reg;

endmodule
